// File: src/bpar_pkg.sv
package bpar_pkg;

	localparam int POS_W     = 25;               // signed box position
	localparam int SIZE_W    = 24;               // unsigned box size
	localparam int CFG_W     = 16;               // every configuration register
	localparam int CFG_IDX_W = 2;
	localparam int LHS_W     = SIZE_W + CFG_W;   // size times a Q8.8-style factor

	localparam logic [CFG_W-1:0] ASPECT_RATIO_RST = 16'd256;
	localparam logic [CFG_W-1:0] SCALE_FACTOR_RST = 16'd256;
	localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 16'd1920;
	localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 16'd1080;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ASPECT_RATIO,
		CFG_SCALE_FACTOR,
		CFG_IMAGE_WIDTH,
		CFG_IMAGE_HEIGHT
	} cfg_idx_t;

endpackage

// File: src/box_pad_to_aspect_ratio_unit.sv
// Pipeline from the start edge to the done strobe: 3 front stages, 40 divider
// stages and 4 back stages, the same stage count for every parameter value.
// Throughput: one box per cycle, sustained; busy stays low, the receiver cannot stall.
// The rate is set by the restoring divider, pipelined one quotient bit per stage.
// Reset (arst_n low, asynchronous) empties the pipeline and loads the register defaults.
module box_pad_to_aspect_ratio_unit #(
	parameter int COORD_FRAC_BITS = 8,
	parameter int RATIO_FRAC_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [bpar_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bpar_pkg::CFG_W-1:0]          cfg_data,
	// command side
	input  logic                                start,
	output logic                                busy,
	input  logic signed [bpar_pkg::POS_W-1:0]   box_x,
	input  logic signed [bpar_pkg::POS_W-1:0]   box_y,
	input  logic [bpar_pkg::SIZE_W-1:0]         box_width,
	input  logic [bpar_pkg::SIZE_W-1:0]         box_height,
	// result side, one-cycle strobe
	output logic                                done,
	output logic signed [bpar_pkg::POS_W-1:0]   padded_x,
	output logic signed [bpar_pkg::POS_W-1:0]   padded_y,
	output logic [bpar_pkg::SIZE_W-1:0]         padded_width,
	output logic [bpar_pkg::SIZE_W-1:0]         padded_height
);
	import bpar_pkg::*;

	// Scaled size after the truncating shift.
	localparam int SW_W  = LHS_W - RATIO_FRAC_BITS;
	// Height times ratio, the right side of the shape test.
	localparam int RHS_W = SW_W + CFG_W;
	// Width grown from the height.
	localparam int NW_W  = RHS_W - RATIO_FRAC_BITS;
	// Any size that can appear inside the pipe.
	localparam int SZ_W  = (NW_W > LHS_W) ? NW_W : LHS_W;
	// Signed working width for positions and clamp limits.
	localparam int PW    = SZ_W + 3;

	// ------------------------------------------------------------------
	// Configuration registers. The user must write them only while the pipe is
	// empty (the block does not enforce it), so every stage reads them directly.
	// ------------------------------------------------------------------
	logic [CFG_W-1:0] aspect_ratio_q;
	logic [CFG_W-1:0] scale_factor_q;
	logic [CFG_W-1:0] image_width_q;
	logic [CFG_W-1:0] image_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aspect_ratio_q <= ASPECT_RATIO_RST;
			scale_factor_q <= SCALE_FACTOR_RST;
			image_width_q  <= IMAGE_WIDTH_RST;
			image_height_q <= IMAGE_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ASPECT_RATIO: aspect_ratio_q <= cfg_data;
				CFG_SCALE_FACTOR: scale_factor_q <= cfg_data;
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A zero ratio counts as one LSB.
	logic [CFG_W-1:0]      ratio_eff;
	logic signed [PW-1:0]  img_w;
	logic signed [PW-1:0]  img_h;

	assign ratio_eff = (aspect_ratio_q == '0) ? CFG_W'(1) : aspect_ratio_q;
	assign img_w     = $signed(PW'(image_width_q) << COORD_FRAC_BITS);
	assign img_h     = $signed(PW'(image_height_q) << COORD_FRAC_BITS);

	// Every transfer is taken; no back pressure exists anywhere in the pipe.
	assign busy = 1'b0;

	// ------------------------------------------------------------------
	// Stage 1: scale both sides by scale_factor, truncate.
	// ------------------------------------------------------------------
	logic [LHS_W-1:0]          prod_w;
	logic [LHS_W-1:0]          prod_h;
	logic                      v_s1;
	logic                      zero_s1;
	logic signed [POS_W-1:0]   x_s1;
	logic signed [POS_W-1:0]   y_s1;
	logic [SIZE_W-1:0]         w_s1;
	logic [SIZE_W-1:0]         h_s1;
	logic [SW_W-1:0]           sw_s1;
	logic [SW_W-1:0]           sh_s1;

	assign prod_w = LHS_W'(box_width) * LHS_W'(scale_factor_q);
	assign prod_h = LHS_W'(box_height) * LHS_W'(scale_factor_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		zero_s1 <= (box_width == '0) || (box_height == '0);
		x_s1    <= box_x;
		y_s1    <= box_y;
		w_s1    <= box_width;
		h_s1    <= box_height;
		sw_s1   <= prod_w[LHS_W-1:RATIO_FRAC_BITS];
		sh_s1   <= prod_h[LHS_W-1:RATIO_FRAC_BITS];
	end

	// ------------------------------------------------------------------
	// Stage 2: recenter after scaling, form both sides of the shape test.
	// A zero-size box keeps its input values from here on.
	// ------------------------------------------------------------------
	logic signed [PW-1:0] grow_w1;
	logic signed [PW-1:0] grow_h1;
	logic                 v_s2;
	logic                 zero_s2;
	logic signed [PW-1:0] x_s2;
	logic signed [PW-1:0] y_s2;
	logic [SZ_W-1:0]      sw_s2;
	logic [SZ_W-1:0]      sh_s2;
	logic [LHS_W-1:0]     lhs_s2;
	logic [RHS_W-1:0]     rhs_s2;

	assign grow_w1 = $signed(PW'(sw_s1)) - $signed(PW'(w_s1));
	assign grow_h1 = $signed(PW'(sh_s1)) - $signed(PW'(h_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		zero_s2 <= zero_s1;
		if (zero_s1) begin
			x_s2  <= PW'(x_s1);
			y_s2  <= PW'(y_s1);
			sw_s2 <= SZ_W'(w_s1);
			sh_s2 <= SZ_W'(h_s1);
		end else begin
			// half the growth, rounded toward minus infinity
			x_s2  <= PW'(x_s1) - (grow_w1 >>> 1);
			y_s2  <= PW'(y_s1) - (grow_h1 >>> 1);
			sw_s2 <= SZ_W'(sw_s1);
			sh_s2 <= SZ_W'(sh_s1);
		end
		lhs_s2 <= LHS_W'(sw_s1) << RATIO_FRAC_BITS;
		rhs_s2 <= RHS_W'(sh_s1) * RHS_W'(ratio_eff);
	end

	// ------------------------------------------------------------------
	// Stage 3: compare width << frac against height * ratio.
	// ------------------------------------------------------------------
	logic                 v_s3;
	logic                 zero_s3;
	logic                 gt_s3;
	logic                 lt_s3;
	logic signed [PW-1:0] x_s3;
	logic signed [PW-1:0] y_s3;
	logic [SZ_W-1:0]      sw_s3;
	logic [SZ_W-1:0]      sh_s3;
	logic [SZ_W-1:0]      nw_s3;
	logic [LHS_W-1:0]     lhs_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		zero_s3 <= zero_s2;
		gt_s3   <= !zero_s2 && (RHS_W'(lhs_s2) > rhs_s2);
		lt_s3   <= !zero_s2 && (RHS_W'(lhs_s2) < rhs_s2);
		x_s3    <= x_s2;
		y_s3    <= y_s2;
		sw_s3   <= sw_s2;
		sh_s3   <= sh_s2;
		nw_s3   <= SZ_W'(rhs_s2[RHS_W-1:RATIO_FRAC_BITS]);
		lhs_s3  <= lhs_s2;
	end

	// ------------------------------------------------------------------
	// Divider entry: apply the too-narrow case (grow the width) while the
	// divider works out the height for the too-wide case.
	// ------------------------------------------------------------------
	logic signed [PW-1:0] grow_nw;
	logic signed [PW-1:0] ent_x;
	logic [SZ_W-1:0]      ent_sw;

	assign grow_nw = $signed(PW'(nw_s3)) - $signed(PW'(sw_s3));
	assign ent_x   = lt_s3 ? (x_s3 - (grow_nw >>> 1)) : x_s3;
	assign ent_sw  = lt_s3 ? nw_s3 : sw_s3;

	// ------------------------------------------------------------------
	// Restoring divider, one quotient bit per stage. dq holds the dividend
	// bits not yet used in its top and the quotient bits so far in its bottom.
	// ------------------------------------------------------------------
	logic [LHS_W-1:0]     div_dq_s   [0:LHS_W-1];
	logic [CFG_W-1:0]     div_rem_s  [0:LHS_W-1];
	logic                 div_v_s    [0:LHS_W-1];
	logic                 div_zero_s [0:LHS_W-1];
	logic                 div_gt_s   [0:LHS_W-1];
	logic signed [PW-1:0] div_x_s    [0:LHS_W-1];
	logic signed [PW-1:0] div_y_s    [0:LHS_W-1];
	logic [SZ_W-1:0]      div_sw_s   [0:LHS_W-1];
	logic [SZ_W-1:0]      div_sh_s   [0:LHS_W-1];

	for (genvar k = 0; k < LHS_W; k++) begin : g_div
		logic [LHS_W-1:0]     dq_in;
		logic [CFG_W-1:0]     rem_in;
		logic                 v_in;
		logic                 zero_in;
		logic                 gt_in;
		logic signed [PW-1:0] x_in;
		logic signed [PW-1:0] y_in;
		logic [SZ_W-1:0]      sw_in;
		logic [SZ_W-1:0]      sh_in;
		logic [CFG_W:0]       trial;
		logic [CFG_W:0]       diff;
		logic                 ge;

		if (k == 0) begin : g_first
			assign dq_in   = lhs_s3;
			assign rem_in  = '0;
			assign v_in    = v_s3;
			assign zero_in = zero_s3;
			assign gt_in   = gt_s3;
			assign x_in    = ent_x;
			assign y_in    = y_s3;
			assign sw_in   = ent_sw;
			assign sh_in   = sh_s3;
		end else begin : g_next
			assign dq_in   = div_dq_s[k-1];
			assign rem_in  = div_rem_s[k-1];
			assign v_in    = div_v_s[k-1];
			assign zero_in = div_zero_s[k-1];
			assign gt_in   = div_gt_s[k-1];
			assign x_in    = div_x_s[k-1];
			assign y_in    = div_y_s[k-1];
			assign sw_in   = div_sw_s[k-1];
			assign sh_in   = div_sh_s[k-1];
		end

		// bring down the next dividend bit, subtract the ratio if it fits
		assign trial = {rem_in, dq_in[LHS_W-1]};
		assign diff  = trial - {1'b0, ratio_eff};
		assign ge    = (trial >= {1'b0, ratio_eff});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[k] <= 1'b0;
			end else begin
				div_v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			div_dq_s[k]   <= {dq_in[LHS_W-2:0], ge};
			div_rem_s[k]  <= ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
			div_zero_s[k] <= zero_in;
			div_gt_s[k]   <= gt_in;
			div_x_s[k]    <= x_in;
			div_y_s[k]    <= y_in;
			div_sw_s[k]   <= sw_in;
			div_sh_s[k]   <= sh_in;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: too-wide case, grow the height to the quotient, recenter.
	// ------------------------------------------------------------------
	logic [SZ_W-1:0]      nh;
	logic signed [PW-1:0] grow_nh;
	logic                 v_s4;
	logic                 zero_s4;
	logic signed [PW-1:0] x_s4;
	logic signed [PW-1:0] y_s4;
	logic [SZ_W-1:0]      sw_s4;
	logic [SZ_W-1:0]      sh_s4;

	assign nh      = SZ_W'(div_dq_s[LHS_W-1]);
	assign grow_nh = $signed(PW'(nh)) - $signed(PW'(div_sh_s[LHS_W-1]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= div_v_s[LHS_W-1];
		end
	end

	always_ff @(posedge clk) begin
		zero_s4 <= div_zero_s[LHS_W-1];
		x_s4    <= div_x_s[LHS_W-1];
		sw_s4   <= div_sw_s[LHS_W-1];
		if (div_gt_s[LHS_W-1]) begin
			y_s4  <= div_y_s[LHS_W-1] - (grow_nh >>> 1);
			sh_s4 <= nh;
		end else begin
			y_s4  <= div_y_s[LHS_W-1];
			sh_s4 <= div_sh_s[LHS_W-1];
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: clamp the corner, max with 0 first, then min with image - size.
	// ------------------------------------------------------------------
	logic signed [PW-1:0] sw4_sg;
	logic signed [PW-1:0] sh4_sg;
	logic signed [PW-1:0] x_lim;
	logic signed [PW-1:0] y_lim;
	logic signed [PW-1:0] x_pos;
	logic signed [PW-1:0] y_pos;
	logic                 v_s5;
	logic                 zero_s5;
	logic signed [PW-1:0] x_s5;
	logic signed [PW-1:0] y_s5;
	logic signed [PW-1:0] sw_s5;
	logic signed [PW-1:0] sh_s5;

	assign sw4_sg = $signed(PW'(sw_s4));
	assign sh4_sg = $signed(PW'(sh_s4));
	assign x_lim  = img_w - sw4_sg;
	assign y_lim  = img_h - sh4_sg;
	assign x_pos  = x_s4[PW-1] ? '0 : x_s4;
	assign y_pos  = y_s4[PW-1] ? '0 : y_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		zero_s5 <= zero_s4;
		sw_s5   <= sw4_sg;
		sh_s5   <= sh4_sg;
		if (zero_s4) begin
			x_s5 <= x_s4;
			y_s5 <= y_s4;
		end else begin
			x_s5 <= (x_pos < x_lim) ? x_pos : x_lim;
			y_s5 <= (y_pos < y_lim) ? y_pos : y_lim;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: clamp the size against the clamped corner. Sizes are never
	// negative here, so only the min remains.
	// ------------------------------------------------------------------
	logic signed [PW-1:0] w_lim;
	logic signed [PW-1:0] h_lim;
	logic                 v_s6;
	logic signed [PW-1:0] x_s6;
	logic signed [PW-1:0] y_s6;
	logic signed [PW-1:0] sw_s6;
	logic signed [PW-1:0] sh_s6;

	assign w_lim = img_w - x_s5;
	assign h_lim = img_h - y_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		x_s6 <= x_s5;
		y_s6 <= y_s5;
		if (zero_s5) begin
			sw_s6 <= sw_s5;
			sh_s6 <= sh_s5;
		end else begin
			sw_s6 <= (sw_s5 < w_lim) ? sw_s5 : w_lim;
			sh_s6 <= (sh_s5 < h_lim) ? sh_s5 : h_lim;
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: saturate into the field ranges and present the result.
	// ------------------------------------------------------------------
	function automatic logic [POS_W-1:0] sat_pos(input logic signed [PW-1:0] v);
		logic [PW-POS_W:0] hi;
		hi = v[PW-1:POS_W-1];
		if ((&hi) || !(|hi)) begin
			sat_pos = v[POS_W-1:0];
		end else if (v[PW-1]) begin
			sat_pos = {1'b1, {(POS_W-1){1'b0}}};
		end else begin
			sat_pos = {1'b0, {(POS_W-1){1'b1}}};
		end
	endfunction

	function automatic logic [SIZE_W-1:0] sat_size(input logic signed [PW-1:0] v);
		if (v[PW-1]) begin
			sat_size = '0;
		end else if (|v[PW-2:SIZE_W]) begin
			sat_size = '1;
		end else begin
			sat_size = v[SIZE_W-1:0];
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		padded_x      <= $signed(sat_pos(x_s6));
		padded_y      <= $signed(sat_pos(y_s6));
		padded_width  <= sat_size(sw_s6);
		padded_height <= sat_size(sh_s6);
	end

endmodule

// File: tb/box_pad_checker.sv
`timescale 1ns / 100ps

module box_pad_checker #(
	parameter int COORD_FRAC_BITS = 8,
	parameter int RATIO_FRAC_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bpar_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bpar_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                start,
	input  logic                                busy,
	input  logic signed [bpar_pkg::POS_W-1:0]   box_x,
	input  logic signed [bpar_pkg::POS_W-1:0]   box_y,
	input  logic [bpar_pkg::SIZE_W-1:0]         box_width,
	input  logic [bpar_pkg::SIZE_W-1:0]         box_height,
	input  logic                                done,
	input  logic signed [bpar_pkg::POS_W-1:0]   padded_x,
	input  logic signed [bpar_pkg::POS_W-1:0]   padded_y,
	input  logic [bpar_pkg::SIZE_W-1:0]         padded_width,
	input  logic [bpar_pkg::SIZE_W-1:0]         padded_height,
	output int                                  fail_count,
	output int                                  outstanding
);
	import bpar_pkg::*;

	localparam longint POS_LO  = -(longint'(1) <<< (POS_W - 1));
	localparam longint POS_HI  = (longint'(1) <<< (POS_W - 1)) - 1;
	localparam longint SIZE_HI = (longint'(1) <<< SIZE_W) - 1;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [SIZE_W-1:0]       w;
		logic [SIZE_W-1:0]       h;
	} box_t;

	box_t            padded_box_q[$];
	logic [CFG_W-1:0] ratio_reg;
	logic [CFG_W-1:0] scale_reg;
	logic [CFG_W-1:0] img_w_reg;
	logic [CFG_W-1:0] img_h_reg;

	function automatic logic signed [POS_W-1:0] sat_pos(longint v);
		if (v < POS_LO)
			v = POS_LO;
		if (v > POS_HI)
			v = POS_HI;
		return POS_W'(v);
	endfunction

	function automatic logic [SIZE_W-1:0] sat_size(longint v);
		if (v < 0)
			v = 0;
		if (v > SIZE_HI)
			v = SIZE_HI;
		return SIZE_W'(v);
	endfunction

	function automatic box_t pad_box(input logic signed [POS_W-1:0] bx, by,
			input logic [SIZE_W-1:0] bw, bh);
		box_t   r;
		longint x, y, sw, sh, ratio, scale, lhs, rhs, grown, iw, ih;
		x = bx;
		y = by;
		sw = bw;
		sh = bh;
		// degenerate box passes through untouched
		if (sw == 0 || sh == 0) begin
			r.x = bx;
			r.y = by;
			r.w = bw;
			r.h = bh;
			return r;
		end
		ratio = ratio_reg;
		if (ratio == 0)
			ratio = 1;
		scale = scale_reg;
		// scale about the center, shift by half the growth, floored
		grown = (sw * scale) >>> RATIO_FRAC_BITS;
		x = x - ((grown - sw) >>> 1);
		sw = grown;
		grown = (sh * scale) >>> RATIO_FRAC_BITS;
		y = y - ((grown - sh) >>> 1);
		sh = grown;
		// grow the short side toward the target ratio
		lhs = sw <<< RATIO_FRAC_BITS;
		rhs = sh * ratio;
		if (lhs > rhs) begin
			grown = lhs / ratio;
			y = y - ((grown - sh) >>> 1);
			sh = grown;
		end else if (lhs < rhs) begin
			grown = rhs >>> RATIO_FRAC_BITS;
			x = x - ((grown - sw) >>> 1);
			sw = grown;
		end
		iw = img_w_reg;
		iw = iw <<< COORD_FRAC_BITS;
		ih = img_h_reg;
		ih = ih <<< COORD_FRAC_BITS;
		// clamp position first, then extent against the clamped position
		x = (x < 0) ? 0 : x;
		x = (x > iw - sw) ? iw - sw : x;
		y = (y < 0) ? 0 : y;
		y = (y > ih - sh) ? ih - sh : y;
		sw = (sw < 0) ? 0 : sw;
		sw = (sw > iw - x) ? iw - x : sw;
		sh = (sh < 0) ? 0 : sh;
		sh = (sh > ih - y) ? ih - y : sh;
		r.x = sat_pos(x);
		r.y = sat_pos(y);
		r.w = sat_size(sw);
		r.h = sat_size(sh);
		return r;
	endfunction

	function automatic bit field_differs(string name, longint want, longint got);
		if (want == got)
			return 1'b0;
		$error("%s: expected %0d, actual %0d", name, want, got);
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		box_t want;
		int   errors;
		if (!arst_n) begin
			ratio_reg <= ASPECT_RATIO_RST;
			scale_reg <= SCALE_FACTOR_RST;
			img_w_reg <= IMAGE_WIDTH_RST;
			img_h_reg <= IMAGE_HEIGHT_RST;
			padded_box_q.delete();
			outstanding <= 0;
			fail_count <= 0;
		end else begin
			errors = 0;
			if (done) begin
				if (padded_box_q.size() == 0) begin
					$error("result transfer with no box outstanding: x %0d y %0d w %0d h %0d",
						padded_x, padded_y, padded_width, padded_height);
					errors++;
				end else begin
					want = padded_box_q.pop_front();
					errors += field_differs("padded_x", want.x, padded_x);
					errors += field_differs("padded_y", want.y, padded_y);
					errors += field_differs("padded_width", want.w, padded_width);
					errors += field_differs("padded_height", want.h, padded_height);
				end
			end
			if (start && !busy)
				padded_box_q.push_back(pad_box(box_x, box_y, box_width, box_height));
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_ASPECT_RATIO: ratio_reg <= cfg_data;
					CFG_SCALE_FACTOR: scale_reg <= cfg_data;
					CFG_IMAGE_WIDTH:  img_w_reg <= cfg_data;
					CFG_IMAGE_HEIGHT: img_h_reg <= cfg_data;
					default: ;
				endcase
			end
			outstanding <= padded_box_q.size();
			fail_count <= fail_count + errors;
		end
	end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import bpar_pkg::*;

	localparam int COORD_FRAC_BITS = 8;
	localparam int RATIO_FRAC_BITS = 8;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 75;
	localparam int WATCHDOG_LIMIT  = 2000;  // counted in idle cycles
	localparam int DRAIN_CYCLES    = 64;
	localparam int SIZE_HI         = (1 << SIZE_W) - 1;

	localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
	localparam logic [SIZE_W-1:0]       SIZE_MAX = {SIZE_W{1'b1}};

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_W-1:0]        cfg_data;
	logic                    start;
	logic                    busy;
	logic signed [POS_W-1:0] box_x;
	logic signed [POS_W-1:0] box_y;
	logic [SIZE_W-1:0]       box_width;
	logic [SIZE_W-1:0]       box_height;
	logic                    done;
	logic signed [POS_W-1:0] padded_x;
	logic signed [POS_W-1:0] padded_y;
	logic [SIZE_W-1:0]       padded_width;
	logic [SIZE_W-1:0]       padded_height;

	int fail_count;
	int outstanding;
	int idle_cycles;
	// image size currently programmed, used only to aim boxes at the image
	int cur_img_w;
	int cur_img_h;

	box_pad_to_aspect_ratio_unit #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS),
		.RATIO_FRAC_BITS(RATIO_FRAC_BITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.start        (start),
		.busy         (busy),
		.box_x        (box_x),
		.box_y        (box_y),
		.box_width    (box_width),
		.box_height   (box_height),
		.done         (done),
		.padded_x     (padded_x),
		.padded_y     (padded_y),
		.padded_width (padded_width),
		.padded_height(padded_height)
	);

	box_pad_checker #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS),
		.RATIO_FRAC_BITS(RATIO_FRAC_BITS)
	) pad_monitor (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.start        (start),
		.busy         (busy),
		.box_x        (box_x),
		.box_y        (box_y),
		.box_width    (box_width),
		.box_height   (box_height),
		.done         (done),
		.padded_x     (padded_x),
		.padded_y     (padded_y),
		.padded_width (padded_width),
		.padded_height(padded_height),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	// 20 ns period
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Watchdog: count cycles with no transfer on either side and no register write,
	// and abort the run once the count reaches the limit.
	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (start && !busy) || done || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("box_pad_to_aspect_ratio_unit verification failed");
		$finish;
	end

	// Drive one box and hold it until the block takes it. Entered and left on a
	// falling edge; start stays high so a following box continues the burst.
	task automatic send_box(input logic signed [POS_W-1:0] x, y,
			input logic [SIZE_W-1:0] w, h);
		start <= 1'b1;
		box_x <= x;
		box_y <= y;
		box_width <= w;
		box_height <= h;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic signed [POS_W-1:0] pick_pos();
		case ($urandom_range(0, 3))
			0:       return POS_MIN;
			1:       return POS_MAX;
			2:       return '0;
			default: return POS_W'($urandom);
		endcase
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		case ($urandom_range(0, 3))
			0:       return SIZE_MAX;
			1:       return SIZE_W'(1);
			2:       return SIZE_W'($urandom_range(1, 255));
			default: return SIZE_W'($urandom);
		endcase
	endfunction

	// Mix raw bit patterns, degenerate boxes and field extremes into a majority
	// of boxes sized and placed around the programmed image.
	task automatic send_random_box();
		logic signed [POS_W-1:0] x, y;
		logic [SIZE_W-1:0]       w, h;
		int                      span_w, span_h, lim_w, lim_h, ofs;
		span_w = ((cur_img_w == 0) ? 1 : cur_img_w) * 256;
		span_h = ((cur_img_h == 0) ? 1 : cur_img_h) * 256;
		lim_w = (2 * span_w > SIZE_HI) ? SIZE_HI : 2 * span_w;
		lim_h = (2 * span_h > SIZE_HI) ? SIZE_HI : 2 * span_h;
		case ($urandom_range(0, 9))
			0: begin
				x = POS_W'($urandom);
				y = POS_W'($urandom);
				w = SIZE_W'($urandom);
				h = SIZE_W'($urandom);
			end
			1: begin
				x = pick_pos();
				y = pick_pos();
				w = $urandom_range(0, 1) ? '0 : pick_size();
				h = (w == '0) ? pick_size() : '0;
			end
			2: begin
				x = pick_pos();
				y = pick_pos();
				w = pick_size();
				h = pick_size();
			end
			default: begin
				w = SIZE_W'($urandom_range(1, lim_w));
				h = SIZE_W'($urandom_range(1, lim_h));
				ofs = int'($urandom_range(0, span_w)) - int'($urandom_range(0, span_w / 4));
				x = POS_W'(ofs);
				ofs = int'($urandom_range(0, span_h)) - int'($urandom_range(0, span_h / 4));
				y = POS_W'(ofs);
			end
		endcase
		send_box(x, y, w, h);
	endtask

	// Program all four registers back to back; write enable drops once at the end.
	task automatic write_settings(input logic [CFG_W-1:0] ratio, scale, iw, ih);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ASPECT_RATIO;
		cfg_data <= ratio;
		@(negedge clk);
		cfg_index <= CFG_SCALE_FACTOR;
		cfg_data <= scale;
		@(negedge clk);
		cfg_index <= CFG_IMAGE_WIDTH;
		cfg_data <= iw;
		@(negedge clk);
		cfg_index <= CFG_IMAGE_HEIGHT;
		cfg_data <= ih;
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_img_w = iw;
		cur_img_h = ih;
	endtask

	// Hold until every accepted box has come back.
	task automatic wait_idle();
		while (outstanding != 0)
			@(negedge clk);
	endtask

	initial begin
		int               phase, count, burst, gap;
		bit               steady;
		logic [CFG_W-1:0] ratio, scale, iw, ih;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		start = 1'b0;
		box_x = '0;
		box_y = '0;
		box_width = '0;
		box_height = '0;
		cur_img_w = IMAGE_WIDTH_RST;
		cur_img_h = IMAGE_HEIGHT_RST;
		gap = 1;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed boxes under the reset settings: ratio 1.0, scale 1.0, 1920x1080.
		// Degenerate boxes come back unchanged.
		send_box(25'sd25600, 25'sd51200, '0, 24'd12800);
		send_box(25'sd25600, 25'sd51200, 24'd12800, '0);
		send_box(POS_MIN, POS_MAX, '0, '0);
		// square box matches the ratio, no padding
		send_box(25'sd25600, 25'sd25600, 24'd16384, 24'd16384);
		// too wide grows in height, too narrow grows in width
		send_box(25'sd128000, 25'sd128000, 24'd51200, 24'd12800);
		send_box(25'sd128000, 25'sd128000, 24'd12800, 24'd51200);
		// box exactly the image, then a box larger than the image
		send_box('0, '0, 24'd491520, 24'd276480);
		send_box('0, '0, 24'd1024000, 24'd768000);
		// box hanging off the top left corner
		send_box(-25'sd12800, -25'sd5120, 24'd25600, 24'd25600);
		// box hanging off the bottom right corner
		send_box(25'sd486400, 25'sd273920, 24'd25600, 24'd10240);
		// field extremes
		send_box('0, '0, SIZE_MAX, SIZE_MAX);
		send_box(POS_MAX, POS_MIN, 24'd1, 24'd1);
		send_box(POS_MIN, POS_MAX, SIZE_MAX, 24'd1);
		send_box(POS_MAX, POS_MAX, 24'd1, SIZE_MAX);
		send_box('1, '1, SIZE_MAX, SIZE_MAX);
		// fractional sizes, odd growth to exercise the floored half shift
		send_box(25'sd257, 25'sd3, 24'd1, 24'd3);
		send_box(25'sd1000, 25'sd1000, 24'd255, 24'd3);
		send_box(25'sd1001, 25'sd999, 24'd3, 24'd257);
		start <= 1'b0;

		for (phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			case (phase)
				// zero ratio acts as one LSB, zero scale collapses the box
				0: begin
					ratio = '0;
					scale = '0;
					iw = 16'd1;
					ih = 16'd1;
				end
				1: begin
					ratio = '1;
					scale = '1;
					iw = '1;
					ih = '1;
				end
				2: begin
					ratio = 16'd1;
					scale = 16'd512;
					iw = '1;
					ih = 16'd1;
				end
				3: begin
					ratio = 16'd455;
					scale = 16'd320;
					iw = 16'd1280;
					ih = 16'd720;
				end
				default: begin
					ratio = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom)
						: CFG_W'($urandom_range(64, 1024));
					scale = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom)
						: CFG_W'($urandom_range(128, 768));
					iw = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom)
						: CFG_W'($urandom_range(16, 4096));
					ih = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom)
						: CFG_W'($urandom_range(16, 4096));
				end
			endcase
			write_settings(ratio, scale, iw, ih);

			// Send in bursts; some phases run back to back with no gaps at all.
			steady = ($urandom_range(0, 3) == 0);
			count = 0;
			while (count < ITEMS_PER_PHASE) begin
				burst = $urandom_range(1, 16);
				// trim the last burst so each phase sends exactly its share
				if (burst > ITEMS_PER_PHASE - count)
					burst = ITEMS_PER_PHASE - count;
				repeat (burst) send_random_box();
				count += burst;
				gap = steady ? 0 : $urandom_range(0, 12);
				if (gap != 0) begin
					start <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			// drop start unless the last gap already did
			if (gap == 0)
				start <= 1'b0;
		end

		// Drain the pipeline, then give stray strobes a chance to show up.
		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("box_pad_to_aspect_ratio_unit verification clean");
		else
			$display("box_pad_to_aspect_ratio_unit verification failed");
		$finish;
	end

endmodule
